// File: src/thb_pkg.sv
package thb_pkg;

   localparam int DEPTH      = 256;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int TIME_W     = 48;
   localparam int PAY_W      = 64;
   localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(196608);

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_READ   = 2'd2,
      REQ_LOCATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCAN
   } state_type;

   // one port: a write or a read per cycle
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [IDX_W-1:0]  addr;
      logic [TIME_W-1:0] wr_time;
      logic [PAY_W-1:0]  wr_payload;
   } mem_cmd_type;

endpackage

// File: src/thb_mem.sv
module thb_mem (
   input  logic                         clock,
   input  thb_pkg::mem_cmd_type         cmd,
   output logic [thb_pkg::TIME_W-1:0]   rd_time,
   output logic [thb_pkg::PAY_W-1:0]    rd_payload
);

   logic [thb_pkg::TIME_W-1:0] time_mem [thb_pkg::DEPTH];
   logic [thb_pkg::PAY_W-1:0]  pay_mem  [thb_pkg::DEPTH];
   logic [thb_pkg::TIME_W-1:0] rd_time_ff;
   logic [thb_pkg::PAY_W-1:0]  rd_payload_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         time_mem[cmd.addr] <= cmd.wr_time;
         pay_mem[cmd.addr]  <= cmd.wr_payload;
      end
      if (cmd.rd_en) begin
         rd_time_ff    <= time_mem[cmd.addr];
         rd_payload_ff <= pay_mem[cmd.addr];
      end
   end

   assign rd_time    = rd_time_ff;
   assign rd_payload = rd_payload_ff;

endmodule

// File: src/timestamped_history_buffer.sv
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+---------------------------
// request  | start, busy, req_type/position/record_time/payload | start=1 and busy=0
// response | rsp_strobe, rsp_ok/found_index/read_*/entry_count  | strobe one cycle, no stall
// csr      | csr_valid, csr_ready, csr_match_window             | csr_valid & csr_ready
//
// Insert and write answer from the execute state; an in-range read adds a read state, an
// out-of-range read answers from the execute state; locate scans every stored entry. The
// one memory port streams an entry per cycle through read / distance / compare.
// Synchronous active-high reset empties the history (count and oldest slot to 0)
// and loads match_window with 3.0; memory contents are not cleared.
// Responses cannot be stalled; a new request may be taken in the strobe cycle.
module timestamped_history_buffer (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_type,
   input  logic [7:0]                         req_position,
   input  logic [47:0]                        req_record_time,
   input  logic [63:0]                        req_record_payload,
   // response
   output logic                               rsp_strobe,
   output logic                               rsp_ok,
   output logic [7:0]                         rsp_found_index,
   output logic [47:0]                        rsp_read_time,
   output logic [63:0]                        rsp_read_payload,
   output logic [8:0]                         rsp_entry_count,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [47:0]                        csr_match_window
);

   localparam int IDX_W  = thb_pkg::IDX_W;
   localparam int CNT_W  = thb_pkg::CNT_W;
   localparam int TIME_W = thb_pkg::TIME_W;
   localparam int PAY_W  = thb_pkg::PAY_W;

   thb_pkg::state_type state_ff, state_in;

   // latched request
   thb_pkg::op_type    op_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [PAY_W-1:0]   pay_ff;

   // history bookkeeping
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [TIME_W-1:0]  window_ff;

   // scan pipeline: issue -> read data -> distance -> compare
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               v1_ff, v1_in;
   logic [IDX_W-1:0]   idx1_ff;
   logic               v2_ff;
   logic [IDX_W-1:0]   idx2_ff;
   logic [TIME_W-1:0]  dist_ff;
   logic [TIME_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   found_ff, found_in;
   logic               hit_ff, hit_in;

   // response registers
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [IDX_W-1:0]   rsp_found_ff, rsp_found_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;
   logic [PAY_W-1:0]   rsp_pay_ff, rsp_pay_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   thb_pkg::mem_cmd_type       mem_cmd;
   logic [TIME_W-1:0]          mem_time;
   logic [PAY_W-1:0]           mem_payload;

   logic                       accept;
   logic                       in_range;
   logic                       full;
   logic                       issue_more;
   logic                       scan_empty;
   logic [TIME_W:0]            diff_sq;
   logic [TIME_W-1:0]          dist_raw;

   thb_mem u_mem (
      .clock      (clock),
      .cmd        (mem_cmd),
      .rd_time    (mem_time),
      .rd_payload (mem_payload)
   );

   assign accept     = start && (state_ff == thb_pkg::ST_IDLE);
   assign in_range   = {1'b0, pos_ff} < count_ff;
   assign full       = count_ff == CNT_W'(thb_pkg::DEPTH);
   assign issue_more = issue_ff < count_ff;
   assign scan_empty = !issue_more && !v1_ff && !v2_ff;

   // |stored - query|: the borrow of stored - query selects the reverse subtract instead
   assign diff_sq  = {1'b0, mem_time} - {1'b0, time_ff};
   assign dist_raw = diff_sq[TIME_W] ? (time_ff - mem_time) : diff_sq[TIME_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         thb_pkg::ST_IDLE: begin
            if (accept) state_in = thb_pkg::ST_EXEC;
         end
         thb_pkg::ST_EXEC: begin
            unique case (op_ff)
               thb_pkg::REQ_INSERT,
               thb_pkg::REQ_WRITE:  state_in = thb_pkg::ST_IDLE;
               thb_pkg::REQ_READ:   state_in = in_range ? thb_pkg::ST_READ
                                                        : thb_pkg::ST_IDLE;
               thb_pkg::REQ_LOCATE: state_in = thb_pkg::ST_SCAN;
            endcase
         end
         thb_pkg::ST_READ: state_in = thb_pkg::ST_IDLE;
         thb_pkg::ST_SCAN: begin
            if (scan_empty) state_in = thb_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control and next values
   always_comb begin
      mem_cmd.wr_en      = 1'b0;
      mem_cmd.rd_en      = 1'b0;
      mem_cmd.addr       = oldest_ff + pos_ff;
      mem_cmd.wr_time    = time_ff;
      mem_cmd.wr_payload = pay_ff;
      count_in      = count_ff;
      oldest_in     = oldest_ff;
      issue_in      = issue_ff;
      v1_in         = 1'b0;
      best_in       = best_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_ok_in     = rsp_ok_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         thb_pkg::ST_IDLE: begin
         end
         thb_pkg::ST_EXEC: begin
            rsp_found_in = '0;
            rsp_time_in  = '0;
            rsp_pay_in   = '0;
            rsp_count_in = count_ff;
            unique case (op_ff)
               thb_pkg::REQ_INSERT: begin
                  mem_cmd.wr_en = 1'b1;
                  if (full) begin
                     // overwrite the oldest entry, count stays at depth
                     mem_cmd.addr = oldest_ff;
                     oldest_in    = oldest_ff + IDX_W'(1);
                  end else begin
                     mem_cmd.addr = oldest_ff + count_ff[IDX_W-1:0];
                     count_in     = count_ff + CNT_W'(1);
                  end
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b1;
                  rsp_count_in  = full ? count_ff : count_ff + CNT_W'(1);
               end
               thb_pkg::REQ_WRITE: begin
                  mem_cmd.wr_en = in_range;
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = in_range;
               end
               thb_pkg::REQ_READ: begin
                  mem_cmd.rd_en = in_range;
                  rsp_strobe_in = !in_range;
                  rsp_ok_in     = 1'b0;
               end
               thb_pkg::REQ_LOCATE: begin
                  issue_in = '0;
                  best_in  = window_ff;
                  found_in = '0;
                  hit_in   = 1'b0;
               end
            endcase
         end
         thb_pkg::ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_ok_in     = 1'b1;
            rsp_time_in   = mem_time;
            rsp_pay_in    = mem_payload;
         end
         thb_pkg::ST_SCAN: begin
            mem_cmd.addr  = oldest_ff + issue_ff[IDX_W-1:0];
            mem_cmd.rd_en = issue_more;
            v1_in         = issue_more;
            if (issue_more) issue_in = issue_ff + CNT_W'(1);
            // strict less-than keeps the oldest among equal distances
            if (v2_ff && (dist_ff < best_ff)) begin
               best_in  = dist_ff;
               found_in = idx2_ff;
               hit_in   = 1'b1;
            end
            if (scan_empty) begin
               rsp_strobe_in = 1'b1;
               rsp_ok_in     = hit_ff;
               rsp_found_in  = hit_ff ? found_ff : '0;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= thb_pkg::ST_IDLE;
         count_ff      <= '0;
         oldest_ff     <= '0;
         window_ff     <= thb_pkg::WINDOW_RESET;
         rsp_strobe_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         issue_ff      <= '0;
         hit_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         oldest_ff     <= oldest_in;
         rsp_strobe_ff <= rsp_strobe_in;
         v1_ff         <= v1_in;
         v2_ff         <= v1_ff;
         issue_ff      <= issue_in;
         hit_ff        <= hit_in;
         if (csr_valid && csr_ready) window_ff <= csr_match_window;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= thb_pkg::op_type'(req_type);
         pos_ff  <= req_position;
         time_ff <= req_record_time;
         pay_ff  <= req_record_payload;
      end
      idx1_ff      <= issue_ff[IDX_W-1:0];
      idx2_ff      <= idx1_ff;
      dist_ff      <= dist_raw;
      best_ff      <= best_in;
      found_ff     <= found_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_pay_ff   <= rsp_pay_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy             = state_ff != thb_pkg::ST_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_found_index  = rsp_found_ff;
   assign rsp_read_time    = rsp_time_ff;
   assign rsp_read_payload = rsp_pay_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule
